// ===== hw/rtl/congestion_window_rate_pushback_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Congestion window rate pushback unit assertion macros
// Shared assertion forms for the rate pushback unit.
// ----------------------------------------------------------------------------
`ifndef CONGESTION_WINDOW_RATE_PUSHBACK_UNIT_DEFINES_SVH
`define CONGESTION_WINDOW_RATE_PUSHBACK_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CWRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cwrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Congestion window rate pushback package
// Widths, constants, register indexes and shared types of the pushback unit.
// ----------------------------------------------------------------------------
package cwrp_pkg;

    localparam int DATA_W              = 32;
    localparam int RATIO_FRAC_BITS_DEF = 16;

    // Serial threshold compare covers the widest operand, ten times a 33-bit fill.
    localparam int CMP_STEPS = 37;
    localparam int CMP_CNT_W = $clog2(CMP_STEPS);

    // All ratio scale factors are taken as k / 20.
    localparam int DIVISOR  = 20;
    localparam int REM_W    = 5;
    localparam int K_W      = 5;
    localparam int K_DEC_HI = 18;
    localparam int K_DEC_LO = 19;
    localparam int K_INC    = 21;

    localparam int  CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_PACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE   = 1'b1;

    typedef enum logic [1:0] {
        FILL_HIGH,
        FILL_OVER,
        FILL_LOW,
        FILL_MID
    } t_fill;

    typedef struct packed {
        logic  done;
        t_fill fill;
    } t_cmp_res;

endpackage

// ===== hw/rtl/cwrp_cmp.sv =====
// ----------------------------------------------------------------------------
// Bit-serial window fill comparator
// Classifies the window fill against the 1.5, 1.0 and 0.1 thresholds, one
// bit per cycle from the least significant bit.
// ----------------------------------------------------------------------------
module cwrp_cmp
    import cwrp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_add_pacing,
    input  logic [DATA_W-1:0] i_flight_bytes,
    input  logic [DATA_W-1:0] i_queue_bytes,
    input  logic [DATA_W-1:0] i_window_bytes,
    output t_cmp_res          o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic [CMP_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_f;
    logic [DATA_W-1:0]    r_q;
    logic [DATA_W-1:0]    r_w;
    logic                 r_tc;
    logic [2:0]           r_th;
    logic                 r_wh;
    logic                 r_bc;
    logic                 r_cc;
    logic                 r_gt15;
    logic                 r_gt10;
    logic                 r_lt01;

    logic       n_t;
    logic       n_tc;
    logic [1:0] n_bsum;
    logic [1:0] n_csum;
    t_fill      n_fill;

    always_comb begin
        n_t    = r_f[0] ^ r_q[0] ^ r_tc;
        n_tc   = (r_f[0] & r_q[0]) | (r_f[0] & r_tc) | (r_q[0] & r_tc);
        n_bsum = {1'b0, r_w[0]} + {1'b0, r_wh} + {1'b0, r_bc};
        n_csum = {1'b0, r_th[0]} + {1'b0, r_th[2]} + {1'b0, r_cc};
        if (r_gt15) begin
            n_fill = FILL_HIGH;
        end else if (r_gt10) begin
            n_fill = FILL_OVER;
        end else if (r_lt01) begin
            n_fill = FILL_LOW;
        end else begin
            n_fill = FILL_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_f    <= i_flight_bytes;
                r_q    <= i_add_pacing ? i_queue_bytes : '0;
                r_w    <= i_window_bytes;
                r_tc   <= 1'b0;
                r_th   <= '0;
                r_wh   <= 1'b0;
                r_bc   <= 1'b0;
                r_cc   <= 1'b0;
                r_gt15 <= 1'b0;
                r_gt10 <= 1'b0;
                r_lt01 <= 1'b0;
            end else if (r_busy) begin
                r_f  <= {1'b0, r_f[DATA_W-1:1]};
                r_q  <= {1'b0, r_q[DATA_W-1:1]};
                r_w  <= {1'b0, r_w[DATA_W-1:1]};
                r_tc <= n_tc;
                r_th <= {r_th[1:0], n_t};
                r_wh <= r_w[0];
                r_bc <= n_bsum[1];
                r_cc <= n_csum[1];
                if (r_th[0] != n_bsum[0]) begin
                    r_gt15 <= r_th[0];
                end
                if (n_t != r_w[0]) begin
                    r_gt10 <= n_t;
                end
                if (r_w[0] != n_csum[0]) begin
                    r_lt01 <= r_w[0];
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CMP_CNT_W'(CMP_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.fill = n_fill;

endmodule

// ===== hw/rtl/cwrp_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial divider by a constant
// Restoring division of the scaled ratio by twenty, one quotient bit per
// cycle from the most significant bit.
// ----------------------------------------------------------------------------
module cwrp_div
    import cwrp_pkg::*;
#(
    parameter int RW = RATIO_FRAC_BITS_DEF + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [RW+K_W-1:0]  i_dividend,
    output logic               o_done,
    output logic [RW+K_W-1:0]  o_quot
);

    localparam int XW = RW + K_W;
    localparam int CW = $clog2(XW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [XW-1:0]    r_x;
    logic [REM_W-1:0] r_rem;

    logic [REM_W:0]   n_trial;
    logic [REM_W:0]   n_diff;
    logic             n_ge;

    always_comb begin
        n_trial = {r_rem, r_x[XW-1]};
        n_diff  = n_trial - (REM_W + 1)'(DIVISOR);
        n_ge    = n_trial >= (REM_W + 1)'(DIVISOR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_x   <= {r_x[XW-2:0], n_ge};
                r_rem <= n_ge ? n_diff[REM_W-1:0] : n_trial[REM_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(XW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_x;

endmodule

// ===== hw/rtl/cwrp_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial rate multiplier
// Scales the target rate by the ratio with one shift-add per ratio bit and
// returns the product without its fraction bits.
// ----------------------------------------------------------------------------
module cwrp_mul
    import cwrp_pkg::*;
#(
    parameter int RW = RATIO_FRAC_BITS_DEF + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_mcand,
    input  logic [RW-1:0]     i_mplier,
    output logic              o_done,
    output logic [DATA_W-1:0] o_prod
);

    localparam int CW = $clog2(RW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_t;
    logic [RW-1:0]     r_r;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_prod;

    logic [DATA_W:0]   n_sum;

    assign n_sum = {1'b0, r_acc} + (r_r[0] ? {1'b0, r_t} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_t    <= i_mcand;
                r_r    <= i_mplier;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_r   <= {1'b0, r_r[RW-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RW - 1)) begin
                    r_prod <= n_sum[DATA_W-1:0];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= n_sum[DATA_W:1];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/congestion_window_rate_pushback_unit.sv =====
// One transaction is in work at a time; the next is taken once the result is
// in the output register. The work is done by the 37-bit serial fill compare,
// the serial divider and the serial multiplier, one bit per cycle each.
// Synchronous active-low reset sets the ratio to 1.0 and clears both registers.
// ----------------------------------------------------------------------------
// Congestion window rate pushback unit
// Tracks the encoding ratio from the window fill and pushes the target
// bitrate back by it, never below the lesser of the target and minimum rate.
// ----------------------------------------------------------------------------
`include "congestion_window_rate_pushback_unit_defines.svh"

module congestion_window_rate_pushback_unit
    import cwrp_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [DATA_W-1:0]      i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DATA_W-1:0]      i_flight_bytes,
    input  logic [DATA_W-1:0]      i_queue_bytes,
    input  logic [DATA_W-1:0]      i_window_bytes,
    input  logic [DATA_W-1:0]      i_target_rate,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [DATA_W-1:0]      o_adjusted_rate,
    output logic [RATIO_FRAC_BITS:0] o_ratio_now,
    output logic                   o_bypassed
);

    localparam int RW = RATIO_FRAC_BITS + 1;
    localparam int XW = RW + K_W;
    localparam logic [RW-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DIV,
        S_MST,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    t_state            r_state;
    logic              r_add_pacing;
    logic [DATA_W-1:0] r_min_rate;
    logic [RW-1:0]     r_ratio;
    logic [DATA_W-1:0] r_tgt;
    logic              r_tgt_lt_min;
    logic [DATA_W-1:0] r_adj;
    logic              r_byp;
    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_adj;
    logic [RW-1:0]     r_o_ratio;
    logic              r_o_byp;

    t_cmp_res          n_cmp;
    logic              n_cmp_start;
    logic              n_div_start;
    logic              n_div_done;
    logic [XW-1:0]     n_quot;
    logic [K_W-1:0]    n_k;
    logic [XW-1:0]     n_dividend;
    logic [RW-1:0]     n_new_ratio;
    logic              n_mul_start;
    logic              n_mul_done;
    logic [DATA_W-1:0] n_prod;
    logic              n_out_free;

    always_comb begin
        case (n_cmp.fill)
            FILL_HIGH: n_k = K_W'(K_DEC_HI);
            FILL_OVER: n_k = K_W'(K_DEC_LO);
            default:   n_k = K_W'(K_INC);
        endcase
        n_dividend  = XW'(r_ratio) * XW'(n_k);
        n_new_ratio = ((n_cmp.fill == FILL_MID) && (n_quot > XW'(RATIO_ONE))) ?
                      RATIO_ONE : n_quot[RW-1:0];
        n_cmp_start = (r_state == S_IDLE) && i_valid && (i_window_bytes != '0);
        n_div_start = (r_state == S_CMP) && n_cmp.done && (n_cmp.fill != FILL_LOW);
        n_mul_start = (r_state == S_MST);
        n_out_free  = !r_o_valid || i_ready;
    end

    cwrp_cmp u_cmp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (n_cmp_start),
        .i_add_pacing   (r_add_pacing),
        .i_flight_bytes (i_flight_bytes),
        .i_queue_bytes  (i_queue_bytes),
        .i_window_bytes (i_window_bytes),
        .o_res          (n_cmp)
    );

    cwrp_div #(
        .RW (RW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .o_done     (n_div_done),
        .o_quot     (n_quot)
    );

    cwrp_mul #(
        .RW (RW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_mul_start),
        .i_mcand  (r_tgt),
        .i_mplier (r_ratio),
        .o_done   (n_mul_done),
        .o_prod   (n_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_add_pacing <= 1'b0;
            r_min_rate   <= '0;
            r_ratio      <= RATIO_ONE;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ADD_PACING: r_add_pacing <= i_cfg_data[0];
                    CFG_MIN_RATE:   r_min_rate   <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (r_o_valid && i_ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tgt <= i_target_rate;
                        if (i_window_bytes == '0) begin
                            r_adj   <= i_target_rate;
                            r_byp   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_byp   <= 1'b0;
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    if (n_cmp.done) begin
                        if (n_cmp.fill == FILL_LOW) begin
                            r_ratio <= RATIO_ONE;
                            r_state <= S_MST;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (n_div_done) begin
                        r_ratio <= n_new_ratio;
                        r_state <= S_MST;
                    end
                end
                S_MST: begin
                    r_tgt_lt_min <= r_tgt < r_min_rate;
                    r_state      <= S_MUL;
                end
                S_MUL: begin
                    if (n_mul_done) begin
                        r_adj   <= n_prod;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_adj < r_min_rate) begin
                        r_adj <= r_tgt_lt_min ? r_tgt : r_min_rate;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_adj   <= r_adj;
                        r_o_ratio <= r_ratio;
                        r_o_byp   <= r_byp;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_adjusted_rate = r_o_adj;
    assign o_ratio_now     = r_o_ratio;
    assign o_bypassed      = r_o_byp;

    `CWRP_ASSERT_NOW(a_ratio_max, i_clk, i_rst_n, 1'b1, r_ratio <= RATIO_ONE,
        "Ratio above one")
    `CWRP_ASSERT_NEXT(a_ratio_idle, i_clk, i_rst_n, r_state == S_IDLE, $stable(r_ratio),
        "Ratio moved while idle")
    `CWRP_ASSERT_NOW(a_fin_bound, i_clk, i_rst_n, r_state == S_FIN, r_adj <= r_tgt,
        "Product above target")
    `CWRP_ASSERT_NOW(a_cmp_done, i_clk, i_rst_n, n_cmp.done, r_state == S_CMP,
        "Compare done out of order")
    `CWRP_ASSERT_NOW(a_div_done, i_clk, i_rst_n, n_div_done, r_state == S_DIV,
        "Divide done out of order")

endmodule
